>>> design/lkvc_pkg.sv
// Package for the LRU key-value cache: field widths, operation codes and
// fixed constants. It depends on nothing and is imported by the top level.
package lkvc_pkg;

    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the input tuser.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Value returned by a get that misses.
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

endpackage

>>> design/lkvc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used by the LRU key-value cache for its entry store.
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/lru_key_value_cache.sv
// Top level of the LRU key-value cache: sequencer, valid bits and recency logic.
// Depends on lkvc_pkg and on the lkvc_ram entry store.
//
// Usage: each input beat on the s_ channel is one operation. s_tuser[0] selects
// get (0) or put (1); s_tdata carries the key in bits 30:0 and the put value in
// bits 62:31. Every operation returns exactly one beat on the m_ channel with
// the read value in m_tdata, a hit flag in m_tuser[0] and an evicted flag in
// m_tuser[1]. The capacity register is written through cfg_we/cfg_wdata; the
// user is to write it only while the block is idle, as the block itself does
// not enforce this. 0 acts as 1 and values above ENTRIES act as ENTRIES.
// Timing: one operation is handled at a time. A scan pass reads every entry
// of the store, one per cycle, through the single RAM read port and one shared
// key/age compare unit; a second read-modify-write pass then rewrites the ages.
// A get that misses skips the second pass and goes to the result register
// through the done state. s_tready is high only while the sequencer is idle,
// and a new beat may be taken while the previous result still waits in the
// output register. If the receiver stalls, a finished result waits until the
// output register is free. Reset empties the cache at once through per-entry
// valid bits and sets the capacity to 16; the key and value store is not cleared.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Capacity register write port.
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,
    // Operation input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // lookup_key[30:0], put_value[62:31], zero
    input  logic [0:0]            s_tuser,   // mode
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VAL_W-1:0]      m_tdata,   // read_value
    output logic [1:0]            m_tuser    // hit, evicted
);

    localparam int IW   = $clog2(ENTRIES);       // entry index and age width
    localparam int CW   = $clog2(ENTRIES + 1);   // count width, holds ENTRIES
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int RW   = IW + KEY_W + VAL_W;    // RAM word: age, key, value

    // Control state.
    logic [2:0]         state_reg;
    logic [CW-1:0]      ptr_reg;
    logic               rd_vld_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CW-1:0]      used_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic               hit_reg;
    logic               slot_found_reg;
    logic               evict_reg;
    logic               m_tvalid_reg;

    // Operation payload and scan results.
    logic               mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [IW-1:0]      hit_age_reg;
    logic [VAL_W-1:0]   hit_val_reg;
    logic [IW-1:0]      slot_idx_reg;
    logic [VAL_W-1:0]   m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic               in_fire;
    logic               scan_last;
    logic               ram_re;
    logic               ram_we;
    logic [RW-1:0]      ram_rdata;
    logic [RW-1:0]      ram_wdata;
    logic [CMPW-1:0]    cap_wide;
    logic [CW-1:0]      cap_eff;
    logic               e_valid;
    logic [IW-1:0]      e_age;
    logic [KEY_W-1:0]   e_key;
    logic [VAL_W-1:0]   e_val;
    logic               e_match;
    logic               e_old;
    logic               e_free;
    logic               e_is_slot;
    logic [IW-1:0]      new_age;
    logic [KEY_W-1:0]   new_key;
    logic [VAL_W-1:0]   new_val;
    logic               out_load;
    logic               m_tvalid_next;
    logic               is_insert;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign scan_last = (ptr_reg == CW'(ENTRIES));
    assign ram_re    = ((state_reg == ST_SCAN) || (state_reg == ST_UPD)) && !scan_last;
    assign ram_we    = (state_reg == ST_UPD) && rd_vld_reg;
    assign is_insert = (mode_reg == MODE_PUT) && !hit_reg;

    // Effective capacity: zero acts as one, saturate at the store depth.
    always_comb begin
        if (cap_reg == '0) begin
            cap_wide = CMPW'(1);
        end else if (CMPW'(cap_reg) > CMPW'(ENTRIES)) begin
            cap_wide = CMPW'(ENTRIES);
        end else begin
            cap_wide = CMPW'(cap_reg);
        end
    end
    assign cap_eff = cap_wide[CW-1:0];

    lkvc_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (rd_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    // Shared compare unit, looking at the entry read in the previous cycle.
    assign e_valid   = valid_reg[rd_idx_reg];
    assign e_val     = ram_rdata[VAL_W-1:0];
    assign e_key     = ram_rdata[VAL_W +: KEY_W];
    assign e_age     = ram_rdata[VAL_W+KEY_W +: IW];
    assign e_match   = e_valid && (e_key == key_reg);
    // The oldest entries, whose ages reach capacity-1, go when the cache is full.
    assign e_old     = evict_reg && e_valid && (CW'(e_age) >= (cap_eff - CW'(1)));
    assign e_free    = !e_valid || e_old;
    assign e_is_slot = (rd_idx_reg == slot_idx_reg);

    // Rewrite of one entry during the update pass.
    always_comb begin
        new_age = e_age;
        new_key = e_key;
        new_val = e_val;
        if (hit_reg) begin
            if (rd_idx_reg == hit_idx_reg) begin
                new_age = '0;
                if (mode_reg == MODE_PUT) begin
                    new_val = val_reg;
                end
            end else if (e_valid && (e_age < hit_age_reg)) begin
                new_age = e_age + IW'(1);
            end
        end else begin
            if (e_is_slot) begin
                new_age = '0;
                new_key = key_reg;
                new_val = val_reg;
            end else if (e_valid && !e_old) begin
                new_age = e_age + IW'(1);
            end
        end
    end
    assign ram_wdata = {new_age, new_key, new_val};

    // Sequencer and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            used_reg       <= '0;
            cap_reg        <= CAP_RESET;
            hit_reg        <= 1'b0;
            slot_found_reg <= 1'b0;
            evict_reg      <= 1'b0;
        end else begin
            rd_vld_reg <= ram_re;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        state_reg      <= ST_SCAN;
                        ptr_reg        <= '0;
                        hit_reg        <= 1'b0;
                        slot_found_reg <= 1'b0;
                        evict_reg      <= (used_reg >= cap_eff);
                    end
                end
                ST_SCAN: begin
                    if (rd_vld_reg) begin
                        if (e_match) begin
                            hit_reg <= 1'b1;
                        end
                        if (e_free && !slot_found_reg) begin
                            slot_found_reg <= 1'b1;
                        end
                    end
                    if (scan_last) begin
                        state_reg <= ST_DEC;
                    end else begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                ST_DEC: begin
                    ptr_reg <= '0;
                    if ((mode_reg == MODE_GET) && !hit_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_UPD;
                    end
                    if (is_insert) begin
                        used_reg <= evict_reg ? cap_eff : used_reg + CW'(1);
                    end
                end
                ST_UPD: begin
                    if (rd_vld_reg && !hit_reg) begin
                        if (e_is_slot) begin
                            valid_reg[rd_idx_reg] <= 1'b1;
                        end else if (e_old) begin
                            valid_reg[rd_idx_reg] <= 1'b0;
                        end
                    end
                    if (scan_last) begin
                        state_reg <= ST_DONE;
                    end else begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: a finished result loads once the previous beat is gone.
    assign out_load      = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = (state_reg == ST_DONE) || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= ptr_reg[IW-1:0];
        if (in_fire) begin
            mode_reg <= s_tuser[0];
            key_reg  <= s_tdata[KEY_W-1:0];
            val_reg  <= s_tdata[KEY_W +: VAL_W];
        end
        if ((state_reg == ST_SCAN) && rd_vld_reg) begin
            if (e_match) begin
                hit_idx_reg <= rd_idx_reg;
                hit_age_reg <= e_age;
                hit_val_reg <= e_val;
            end
            if (e_free && !slot_found_reg) begin
                slot_idx_reg <= rd_idx_reg;
            end
        end
        if (out_load) begin
            if (mode_reg == MODE_PUT) begin
                m_tdata_reg <= val_reg;
            end else if (hit_reg) begin
                m_tdata_reg <= hit_val_reg;
            end else begin
                m_tdata_reg <= MISS_VALUE;
            end
            m_tuser_reg <= {is_insert && evict_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // Occupancy count agrees with the valid bits between operations.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == int'(used_reg)))
        else $error("entry count disagrees with valid bits");

    // The count never exceeds the store depth.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(ENTRIES))
        else $error("entry count above store depth");

    // An insertion always finds a free or evicted slot during the scan.
    a_slot_found: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DEC) && (mode_reg == MODE_PUT) && !hit_reg) |-> slot_found_reg)
        else $error("insertion without a free slot");

    // After an insertion the occupancy respects the effective capacity.
    a_cap_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && is_insert) |-> (used_reg <= cap_eff))
        else $error("occupancy above capacity after insertion");
`endif

endmodule
